@@ src/cne_pkg.sv @@
// Shared types and constants for the caret notation escaper.
`timescale 1ns / 1ps

package cne_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SHOW_TAB    = 2'd0;
    localparam logic [1:0] CFG_ESCAPE_CTRL = 2'd1;
    localparam logic [1:0] CFG_MARK_EOL    = 2'd2;

    // Byte values that the rendering rules look for or produce.
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_NL      = 8'd10;
    localparam logic [7:0] CTRL_TOP   = 8'd31;
    localparam logic [7:0] CH_DEL     = 8'd127;
    localparam logic [7:0] HIGH_LO    = 8'd128;
    localparam logic [7:0] HIGH_END   = 8'd160;
    localparam logic [7:0] CARET_OFS  = 8'd64;
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_QUERY   = 8'h3F;
    localparam logic [7:0] CH_M       = 8'h4D;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_I       = 8'h49;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;

    // Mode bits written over the configuration port.
    typedef struct packed {
        logic show_tab_marks;
        logic escape_controls;
        logic mark_line_ends;
    } t_mode;

    // Rendered form of one input byte: bytes[0] goes out first.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
    } t_render;

endpackage

@@ src/cne_render.sv @@
// Combinational rendering of one byte into its one to four visible bytes.
`timescale 1ns / 1ps

module cne_render (
    input  cne_pkg::t_mode   i_mode,
    input  logic [7:0]       i_byte,
    output cne_pkg::t_render o_item
);

    // Rules in order of precedence: tab, control escape, line end, pass.
    always_comb begin
        o_item.bytes = '0;
        o_item.count = 3'd1;
        priority if (i_mode.show_tab_marks && i_byte == cne_pkg::CH_TAB) begin
            o_item.bytes[0] = cne_pkg::CH_CARET;
            o_item.bytes[1] = cne_pkg::CH_I;
            o_item.count    = 3'd2;
        end else if (i_mode.escape_controls && i_byte != cne_pkg::CH_NL
                     && i_byte != cne_pkg::CH_TAB) begin
            priority if (i_byte <= cne_pkg::CTRL_TOP) begin
                o_item.bytes[0] = cne_pkg::CH_CARET;
                o_item.bytes[1] = i_byte + cne_pkg::CARET_OFS;
                o_item.count    = 3'd2;
            end else if (i_byte == cne_pkg::CH_DEL) begin
                o_item.bytes[0] = cne_pkg::CH_CARET;
                o_item.bytes[1] = cne_pkg::CH_QUERY;
                o_item.count    = 3'd2;
            end else if (i_byte >= cne_pkg::HIGH_LO && i_byte < cne_pkg::HIGH_END) begin
                o_item.bytes[0] = cne_pkg::CH_M;
                o_item.bytes[1] = cne_pkg::CH_DASH;
                o_item.bytes[2] = cne_pkg::CH_CARET;
                o_item.bytes[3] = i_byte - cne_pkg::CARET_OFS;
                o_item.count    = 3'd4;
            end else begin
                o_item.bytes[0] = i_byte;
            end
        end else if (i_mode.mark_line_ends && i_byte == cne_pkg::CH_NL) begin
            o_item.bytes[0] = cne_pkg::CH_DOLLAR;
            o_item.bytes[1] = cne_pkg::CH_NL;
            o_item.count    = 3'd2;
        end else begin
            o_item.bytes[0] = i_byte;
        end
    end

endmodule

@@ src/cne_emitter.sv @@
// Output register that sends a rendered item out one byte per transaction.
`timescale 1ns / 1ps

module cne_emitter (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  cne_pkg::t_render i_item,
    input  logic             i_out_stall,
    output logic             o_take,
    output logic             o_out_valid,
    output logic [7:0]       o_out_byte,
    output logic             o_last_of_item
);

    logic [2:0]      r_left;
    logic [2:0]      n_left;
    logic [3:0][7:0] r_bytes;
    logic [3:0][7:0] n_bytes;
    logic            w_fire;

    // A new item may load when the register is empty or its last byte leaves now.
    assign w_fire = (r_left != 3'd0) && !i_out_stall;
    assign o_take = (r_left == 3'd0) || ((r_left == 3'd1) && !i_out_stall);

    // Load a fresh item, or shift the held bytes down after each transaction.
    always_comb begin
        n_left  = r_left;
        n_bytes = r_bytes;
        if (i_load && o_take) begin
            n_left  = i_item.count;
            n_bytes = i_item.bytes;
        end else if (w_fire) begin
            n_left     = r_left - 3'd1;
            n_bytes[0] = r_bytes[1];
            n_bytes[1] = r_bytes[2];
            n_bytes[2] = r_bytes[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 3'd0;
        end else begin
            r_left <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
    end

    // The head byte is always the one on offer.
    assign o_out_valid    = (r_left != 3'd0);
    assign o_out_byte     = r_bytes[0];
    assign o_last_of_item = (r_left == 3'd1);

endmodule

@@ src/caret_notation_escaper.sv @@
// Top level of the caret notation escaper.
`timescale 1ns / 1ps

// Takes one byte per input transaction and gives its visible form as one to
// four output transactions, the last marked by o_last_of_item. Plain text
// streams at one byte per clock while the output is not stalled. An escaped
// byte occupies the output register until all of its output bytes are out:
// two for caret forms and line ends, and four for M-^ forms. The next byte
// waits in the input register for that time, so the input stalls until the
// last output byte of the item leaves, and longer if the output is stalled.
// Each byte passes through the input register and then the output register.
// Mode registers (index 0 tab marks, 1 control escaping, 2 line-end marking)
// are written through the configuration channel, which is always ready;
// write them only while no item is in flight.
module caret_notation_escaper (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic       i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_item
);

    cne_pkg::t_mode   r_mode;
    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             w_take;
    cne_pkg::t_render w_item;

    assign o_cfg_ready = 1'b1;

    // Mode register writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                cne_pkg::CFG_SHOW_TAB:    r_mode.show_tab_marks  <= i_cfg_data;
                cne_pkg::CFG_ESCAPE_CTRL: r_mode.escape_controls <= i_cfg_data;
                cne_pkg::CFG_MARK_EOL:    r_mode.mark_line_ends  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input register: refills whenever its byte moves on or it is empty.
    assign o_in_stall = r_in_valid && !w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_in_byte;
        end
    end

    // Rendering between input and output registers.
    cne_render u_render (
        .i_mode (r_mode),
        .i_byte (r_in_byte),
        .o_item (w_item)
    );

    cne_emitter u_emitter (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (r_in_valid),
        .i_item         (w_item),
        .i_out_stall    (i_out_stall),
        .o_take         (w_take),
        .o_out_valid    (o_out_valid),
        .o_out_byte     (o_out_byte),
        .o_last_of_item (o_last_of_item)
    );

endmodule

@@ src/cne_checker.sv @@
// Port-level assertions for the caret notation escaper, bound to the top level.
`timescale 1ns / 1ps

module cne_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out_byte,
    input logic       o_last_of_item
);

    // A stalled output transaction holds its byte and marker.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_last_of_item))
        else $error("output changed while stalled");

    // Nothing is offered in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid straight after reset");

    // The bytes of one item leave without gaps.
    a_item_unbroken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_of_item |=> o_out_valid)
        else $error("gap inside an expanded item");

    // An empty output register never holds the input back.
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with output empty");

endmodule

bind caret_notation_escaper cne_checker u_cne_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_out_byte     (o_out_byte),
    .o_last_of_item (o_last_of_item)
);

@@ test/tb_caret_notation_escaper.sv @@
// Self-checking testbench for the caret notation escaper.
`timescale 1ns / 1ps

module tb_caret_notation_escaper;

    // Index that maps to no register; writes to it must change nothing.
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    // Mode settings as {show_tab_marks, escape_controls, mark_line_ends}.
    localparam cne_pkg::t_mode MODE_NONE = cne_pkg::t_mode'(3'b000);
    localparam cne_pkg::t_mode MODE_TAB  = cne_pkg::t_mode'(3'b100);
    localparam cne_pkg::t_mode MODE_ESC  = cne_pkg::t_mode'(3'b010);
    localparam cne_pkg::t_mode MODE_EOL  = cne_pkg::t_mode'(3'b001);
    localparam cne_pkg::t_mode MODE_ALL  = cne_pkg::t_mode'(3'b111);

    // A zero count means the row is checked against the predictor.
    localparam cne_pkg::t_render FROM_PREDICTOR = '0;

    localparam int DIRECTED_ROWS = 25;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 57;
    localparam int LONG_HOLD     = 80;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_out_char;

    typedef struct {
        cne_pkg::t_mode   mode;
        logic [7:0]       ch;
        cne_pkg::t_render fixed;
    } t_stim_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic       i_cfg_data;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_in_byte;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_out_byte;
    logic       o_last_of_item;

    // Characters still to be rendered, oldest first.
    t_out_char      awaited_chars[$];
    cne_pkg::t_mode mode_now;
    t_stim_row      dir_rows [DIRECTED_ROWS];
    int             mismatch_count = 0;
    bit             idle_on = 1'b1;
    bit             hold_request = 1'b0;

    caret_notation_escaper dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_byte      (i_in_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_last_of_item (o_last_of_item)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog against a hung handshake.
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Builds a rendered sequence of n characters, first character in b0.
    function automatic cne_pkg::t_render chars(input int n, input logic [7:0] b0,
                                               input logic [7:0] b1 = 8'h00,
                                               input logic [7:0] b2 = 8'h00,
                                               input logic [7:0] b3 = 8'h00);
        cne_pkg::t_render r;
        r = '0;
        r.bytes[0] = b0;
        r.bytes[1] = b1;
        r.bytes[2] = b2;
        r.bytes[3] = b3;
        r.count = 3'(n);
        return r;
    endfunction

    // Visible form of one byte under the given mode bits.
    function automatic cne_pkg::t_render caret_render(input logic [7:0] c,
                                                      input cne_pkg::t_mode m);
        cne_pkg::t_render r;
        if (m.show_tab_marks && c == cne_pkg::CH_TAB) begin
            r = chars(2, cne_pkg::CH_CARET, cne_pkg::CH_I);
        end else if (m.escape_controls && c != cne_pkg::CH_NL
                     && c != cne_pkg::CH_TAB) begin
            if (c <= cne_pkg::CTRL_TOP) begin
                r = chars(2, cne_pkg::CH_CARET, c + cne_pkg::CARET_OFS);
            end else if (c == cne_pkg::CH_DEL) begin
                r = chars(2, cne_pkg::CH_CARET, cne_pkg::CH_QUERY);
            end else if (c >= cne_pkg::HIGH_LO && c < cne_pkg::HIGH_END) begin
                r = chars(4, cne_pkg::CH_M, cne_pkg::CH_DASH, cne_pkg::CH_CARET,
                          c - cne_pkg::CARET_OFS);
            end else begin
                r = chars(1, c);
            end
        end else if (m.mark_line_ends && c == cne_pkg::CH_NL) begin
            r = chars(2, cne_pkg::CH_DOLLAR, cne_pkg::CH_NL);
        end else begin
            r = chars(1, c);
        end
        return r;
    endfunction

    // Random byte, weighted towards the bytes that the rules rewrite.
    function automatic logic [7:0] pick_byte();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: c = 8'($urandom_range(0, 255));
            4:          c = 8'($urandom_range(0, 31));
            5:          c = cne_pkg::CH_TAB;
            6:          c = cne_pkg::CH_NL;
            7:          c = cne_pkg::CH_DEL;
            8:          c = 8'($urandom_range(128, 159));
            default:    c = 8'($urandom_range(32, 126));
        endcase
        return c;
    endfunction

    // Stops offering input and waits until every rendered character is out.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (awaited_chars.size() != 0) @(posedge i_clk);
    endtask

    // One register write; valid stays high for a following write.
    task automatic cfg_write(input logic [1:0] idx, input logic d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            cne_pkg::CFG_SHOW_TAB:    mode_now.show_tab_marks  = d;
            cne_pkg::CFG_ESCAPE_CTRL: mode_now.escape_controls = d;
            cne_pkg::CFG_MARK_EOL:    mode_now.mark_line_ends  = d;
            default:                  ;
        endcase
    endtask

    // Sets all three mode bits once the block has gone quiet.
    task automatic cfg_apply(input cne_pkg::t_mode m, input bit poke_unused);
        wait_drained();
        if (poke_unused) cfg_write(CFG_UNUSED, 1'b1);
        cfg_write(cne_pkg::CFG_SHOW_TAB, m.show_tab_marks);
        cfg_write(cne_pkg::CFG_ESCAPE_CTRL, m.escape_controls);
        cfg_write(cne_pkg::CFG_MARK_EOL, m.mark_line_ends);
        i_cfg_valid <= 1'b0;
    endtask

    // Offers one byte, records its rendering once the transaction completes.
    task automatic send_byte(input logic [7:0] c, input cne_pkg::t_render fixed);
        cne_pkg::t_render want;
        i_in_valid <= 1'b1;
        i_in_byte  <= c;
        do @(posedge i_clk); while (o_in_stall);
        want = (fixed.count != 0) ? fixed : caret_render(c, mode_now);
        for (int k = 0; k < int'(want.count); k++) begin
            awaited_chars.push_back('{ch: want.bytes[k], last: (k == want.count - 1)});
        end
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    // Output stall: short random bursts, plus one long hold on request.
    initial begin : out_stall_gen
        int burst_left;
        int hold_left;
        burst_left = 0;
        hold_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (burst_left > 0) begin
                burst_left--;
                i_out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                burst_left = $urandom_range(0, 2);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Compares each output transaction with the oldest awaited character.
    always @(posedge i_clk) begin : out_check
        t_out_char want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_chars.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected output: byte %h last %b", o_out_byte, o_last_of_item);
            end else begin
                want = awaited_chars.pop_front();
                if (want.ch !== o_out_byte || want.last !== o_last_of_item) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Mismatch: expected byte %h last %b, got byte %h last %b",
                                 want.ch, want.last, o_out_byte, o_last_of_item);
                end
            end
        end
    end

    // Stimulus: directed table first, then random phases under several modes.
    initial begin : stimulus
        cne_pkg::t_mode m;
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= cne_pkg::CFG_SHOW_TAB;
        i_cfg_data  <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_byte   <= 8'h00;
        mode_now = MODE_NONE;

        dir_rows = '{
            '{MODE_NONE, 8'h00, chars(1, 8'h00)},
            '{MODE_NONE, 8'hFF, chars(1, 8'hFF)},
            '{MODE_NONE, cne_pkg::CH_TAB, chars(1, cne_pkg::CH_TAB)},
            '{MODE_NONE, cne_pkg::CH_NL, chars(1, cne_pkg::CH_NL)},
            '{MODE_NONE, 8'h80, FROM_PREDICTOR},
            '{MODE_ESC, 8'h00, chars(2, cne_pkg::CH_CARET, 8'h40)},
            '{MODE_ESC, cne_pkg::CTRL_TOP, chars(2, cne_pkg::CH_CARET, 8'h5F)},
            '{MODE_ESC, cne_pkg::CH_TAB, chars(1, cne_pkg::CH_TAB)},
            '{MODE_ESC, cne_pkg::CH_NL, chars(1, cne_pkg::CH_NL)},
            '{MODE_ESC, cne_pkg::CH_DEL,
              chars(2, cne_pkg::CH_CARET, cne_pkg::CH_QUERY)},
            '{MODE_ESC, cne_pkg::HIGH_LO,
              chars(4, cne_pkg::CH_M, cne_pkg::CH_DASH, cne_pkg::CH_CARET, 8'h40)},
            '{MODE_ESC, 8'h9F,
              chars(4, cne_pkg::CH_M, cne_pkg::CH_DASH, cne_pkg::CH_CARET, 8'h5F)},
            '{MODE_ESC, cne_pkg::HIGH_END, chars(1, cne_pkg::HIGH_END)},
            '{MODE_ESC, 8'hFF, chars(1, 8'hFF)},
            '{MODE_ESC, 8'h1B, FROM_PREDICTOR},
            '{MODE_ESC, 8'h7E, FROM_PREDICTOR},
            '{MODE_EOL, cne_pkg::CH_NL,
              chars(2, cne_pkg::CH_DOLLAR, cne_pkg::CH_NL)},
            '{MODE_EOL, cne_pkg::CH_TAB, chars(1, cne_pkg::CH_TAB)},
            '{MODE_EOL, 8'h1F, FROM_PREDICTOR},
            '{MODE_TAB, cne_pkg::CH_TAB, chars(2, cne_pkg::CH_CARET, cne_pkg::CH_I)},
            '{MODE_TAB, cne_pkg::CH_NL, FROM_PREDICTOR},
            '{MODE_ALL, cne_pkg::CH_TAB, chars(2, cne_pkg::CH_CARET, cne_pkg::CH_I)},
            '{MODE_ALL, cne_pkg::CH_NL,
              chars(2, cne_pkg::CH_DOLLAR, cne_pkg::CH_NL)},
            '{MODE_ALL, 8'h01, FROM_PREDICTOR},
            '{MODE_ALL, 8'h85, FROM_PREDICTOR}
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Write every register, with a stray write to the unused index first.
        cfg_apply(MODE_NONE, 1'b1);
        foreach (dir_rows[i]) begin
            if (dir_rows[i].mode != mode_now) cfg_apply(dir_rows[i].mode, 1'b0);
            send_byte(dir_rows[i].ch, dir_rows[i].fixed);
        end

        // Random phases; two of them run with no idling, the last among them.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       m = MODE_ALL;
                1:       m = MODE_ESC;
                2:       m = cne_pkg::t_mode'(3'b101);
                3:       m = MODE_NONE;
                5:       m = cne_pkg::t_mode'(3'b011);
                7:       m = MODE_ALL;
                default: m = cne_pkg::t_mode'($urandom_range(0, 7));
            endcase
            cfg_apply(m, 1'b0);
            idle_on = (p != 3 && p != PHASES - 1);
            // Hold the output off long enough for the input to back up.
            if (p == 1) hold_request = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 4 && k == PHASE_ITEMS / 2) wait_drained();
                send_byte(pick_byte(), FROM_PREDICTOR);
            end
        end

        // Let the tail drain and watch for stray output.
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && awaited_chars.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/cne_pkg.sv
src/cne_render.sv
src/cne_emitter.sv
src/caret_notation_escaper.sv
src/cne_checker.sv
test/tb_caret_notation_escaper.sv
